>>> rtl/assert_macros.svh
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/mtbr_pkg.sv
// Types, constants and the tempering function of the bounded MT19937 generator.
`timescale 1ns / 1ps
`default_nettype none
package mtbr_pkg;

    localparam int unsigned STATE_WORDS = 624;
    localparam int unsigned POS_W       = 10;
    localparam int unsigned SHIFT_DIST  = 397;

    localparam logic [POS_W-1:0] LAST_IDX   = POS_W'(STATE_WORDS - 1);
    localparam logic [POS_W-1:0] FULL_POS   = POS_W'(STATE_WORDS);
    localparam logic [POS_W-1:0] FAR_SPLIT  = POS_W'(STATE_WORDS - SHIFT_DIST);
    localparam logic [POS_W-1:0] FAR_ADD    = POS_W'(SHIFT_DIST);

    localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [31:0] INIT_MULT    = 32'd1812433253;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

    // What the front end decided an item needs.
    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_DRAW = 2'd1,
        CLS_SEED = 2'd2
    } item_class_t;

    typedef struct packed {
        item_class_t cls;
        logic [31:0] seed_value;
        logic [31:0] limit;
    } item_t;

    // Engine status seen by the top level.
    typedef struct packed {
        logic             seeded;
        logic [POS_W-1:0] pos;
    } eng_status_t;

    // Standard MT19937 output tempering.
    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage
`default_nettype wire

>>> rtl/mtbr_front.sv
// Input side: accepts words, classifies them and queues them for the engine.
`timescale 1ns / 1ps
`default_nettype none
module mtbr_front
    import mtbr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // seed_value [31:0], limit [63:32]
    input  wire logic        s_tuser,   // kind [0]
    output logic             q_valid,
    output item_t            q_item,
    input  wire logic        q_pop
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    item_t            incoming;
    logic             push;

    // Classify the incoming word.
    always_comb begin
        incoming.seed_value = s_tdata[31:0];
        incoming.limit      = s_tdata[63:32];
        if (s_tuser) begin
            incoming.cls = CLS_SEED;
        end else if (s_tdata[63:32] > 32'd1) begin
            incoming.cls = CLS_DRAW;
        end else begin
            incoming.cls = CLS_ZERO;
        end
    end

    assign s_tready = (count_reg != CNT_FULL);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (q_pop && q_valid) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !(q_pop && q_valid)) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push && q_pop && q_valid) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule
`default_nettype wire

>>> rtl/mtbr_divider.sv
// Restoring divider that yields the remainder, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mtbr_divider
    import mtbr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] div_reg, div_next;
    logic [32:0] trial;

    assign trial     = {rem_reg, quo_reg[31]};
    assign done      = done_reg;
    assign remainder = rem_reg;

    // One shift-and-subtract step per cycle.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = 32'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[31:0];
            end
            quo_next = {quo_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

endmodule
`default_nettype wire

>>> rtl/mtbr_engine.sv
// Back end: state memory, seeding, regeneration, draw and the output register.
`timescale 1ns / 1ps
`default_nettype none
module mtbr_engine
    import mtbr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire item_t       q_item,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // value [31:0]
    output eng_status_t      status
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_SEED_MUL  = 10'b00_0000_0010,
        S_SEED_ADD  = 10'b00_0000_0100,
        S_REG_RD    = 10'b00_0000_1000,
        S_REG_FAR   = 10'b00_0001_0000,
        S_REG_WR    = 10'b00_0010_0000,
        S_DRAW_RD   = 10'b00_0100_0000,
        S_DRAW_WAIT = 10'b00_1000_0000,
        S_DIV       = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             seeded_reg, seeded_next;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic             pending_reg, pending_next;
    logic [31:0]      p_reg, p_next;
    logic [31:0]      prod_reg, prod_next;
    logic [31:0]      y_reg, y_next;
    logic [31:0]      limit_reg, limit_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_data_reg, out_data_next;

    logic [31:0]      mem [STATE_WORDS];
    logic [31:0]      rd_a_reg, rd_b_reg;
    logic [POS_W-1:0] addr_a, addr_b, addr_w;
    logic             wr_en;
    logic [31:0]      wr_data;

    logic [POS_W-1:0] nxt_idx, far_idx;
    logic [31:0]      mul_low;
    logic [31:0]      twisted;
    logic             div_start, div_done;
    logic [31:0]      div_rem;

    assign nxt_idx  = (idx_reg == LAST_IDX) ? '0 : idx_reg + POS_W'(1);
    assign far_idx  = (idx_reg < FAR_SPLIT) ? idx_reg + FAR_ADD : idx_reg - FAR_SPLIT;
    // Only the low word of the seeding product is kept.
    assign mul_low  = INIT_MULT * (p_reg ^ (p_reg >> 30));
    assign twisted  = rd_a_reg ^ (y_reg >> 1) ^ (y_reg[0] ? TWIST_MATRIX : 32'd0);

    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;
    assign status.seeded = seeded_reg;
    assign status.pos    = pos_reg;

    mtbr_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (temper(rd_a_reg)),
        .divisor   (limit_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        seeded_next    = seeded_reg;
        idx_next       = idx_reg;
        pending_next   = pending_reg;
        p_next         = p_reg;
        prod_next      = prod_reg;
        y_next         = y_reg;
        limit_next     = limit_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        addr_a         = idx_reg;
        addr_b         = nxt_idx;
        addr_w         = idx_reg;
        wr_en          = 1'b0;
        wr_data        = twisted;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (q_valid && !out_valid_reg) begin
                    q_pop      = 1'b1;
                    limit_next = q_item.limit;
                    case (q_item.cls)
                        CLS_SEED: begin
                            wr_en        = 1'b1;
                            addr_w       = '0;
                            wr_data      = q_item.seed_value;
                            p_next       = q_item.seed_value;
                            idx_next     = POS_W'(1);
                            pending_next = 1'b0;
                            state_next   = S_SEED_MUL;
                        end
                        CLS_DRAW: begin
                            if (pos_reg >= FULL_POS) begin
                                if (!seeded_reg) begin
                                    wr_en        = 1'b1;
                                    addr_w       = '0;
                                    wr_data      = DEFAULT_SEED;
                                    p_next       = DEFAULT_SEED;
                                    idx_next     = POS_W'(1);
                                    pending_next = 1'b1;
                                    state_next   = S_SEED_MUL;
                                end else begin
                                    idx_next   = '0;
                                    state_next = S_REG_RD;
                                end
                            end else begin
                                state_next = S_DRAW_RD;
                            end
                        end
                        default: begin
                            out_data_next  = '0;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SEED_MUL: begin
                prod_next  = mul_low;
                state_next = S_SEED_ADD;
            end
            S_SEED_ADD: begin
                wr_en   = 1'b1;
                wr_data = prod_reg + 32'(idx_reg);
                p_next  = prod_reg + 32'(idx_reg);
                if (idx_reg == LAST_IDX) begin
                    seeded_next = 1'b1;
                    pos_next    = FULL_POS;
                    if (pending_reg) begin
                        idx_next   = '0;
                        state_next = S_REG_RD;
                    end else begin
                        out_data_next = '0;
                        state_next    = S_DONE;
                    end
                end else begin
                    idx_next   = idx_reg + POS_W'(1);
                    state_next = S_SEED_MUL;
                end
            end
            S_REG_RD: begin
                // Fetch the current and the following word.
                state_next = S_REG_FAR;
            end
            S_REG_FAR: begin
                y_next     = (rd_a_reg & HIGH_BIT) | (rd_b_reg & LOW_BITS);
                addr_a     = far_idx;
                state_next = S_REG_WR;
            end
            S_REG_WR: begin
                wr_en = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    pos_next   = '0;
                    state_next = S_DRAW_RD;
                end else begin
                    idx_next   = idx_reg + POS_W'(1);
                    state_next = S_REG_RD;
                end
            end
            S_DRAW_RD: begin
                addr_a     = pos_reg;
                state_next = S_DRAW_WAIT;
            end
            S_DRAW_WAIT: begin
                div_start  = 1'b1;
                pos_next   = pos_reg + POS_W'(1);
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    out_data_next = div_rem;
                    state_next    = S_DONE;
                end
            end
            S_DONE: begin
                // The output register is known free here.
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pos_reg       <= FULL_POS;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        pending_reg  <= pending_next;
        p_reg        <= p_next;
        prod_reg     <= prod_next;
        y_reg        <= y_next;
        limit_reg    <= limit_next;
        out_data_reg <= out_data_next;
    end

    // State word memory: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr_w] <= wr_data;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

endmodule
`default_nettype wire

>>> rtl/mt19937_bounded_random.sv
// Top level of the bounded MT19937 random generator.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Each input word either reseeds the 624-word generator state (kind 1, answers 0) or draws
// a random value below limit (kind 0; a limit of 0 or 1 answers 0 without using a word).
// A seed writes the state words one by one through the seeding multiplier (S_SEED_MUL, S_SEED_ADD).
// A draw runs the 32-step remainder divider; every 624th draw, and the first draw after a seed,
// first regenerates the state word by word (S_REG_RD, S_REG_FAR, S_REG_WR), and a draw
// before any seed also seeds with 5489 first. Items are worked one at a time; a small input
// queue and the output register let both sides stall independently. Every input word
// produces exactly one output word.
module mt19937_bounded_random
    import mtbr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // seed_value [31:0], limit [63:32]
    input  wire logic        s_tuser,   // kind [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // value [31:0]
);

    logic        q_valid;
    item_t       q_item;
    logic        q_pop;
    eng_status_t status;

    mtbr_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    mtbr_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .status   (status)
    );

    // The read position never runs past the end of the store.
    `ASSERT_IMPLIES(a_pos_range, aclk, aresetn, 1'b1, status.pos <= FULL_POS)
    // Until the first seed the store counts as used up.
    `ASSERT_IMPLIES(a_unseeded_pos, aclk, aresetn, !status.seeded, status.pos == FULL_POS)
    // Finishing a seed leaves the store marked for regeneration.
    `ASSERT_IMPLIES(a_seed_marks, aclk, aresetn, $rose(status.seeded), status.pos == FULL_POS)

endmodule
`default_nettype wire
